### hw/rtl/bbf_pkg.sv
// Shared types, constants and sizes for the blocked Bloom filter.
package bbf_pkg;

  localparam int NUM_BLOCKS     = 64;
  localparam int BITS_PER_BLOCK = 512;
  localparam int WORD_BITS      = 64;

  localparam int BLK_W  = $clog2(NUM_BLOCKS);
  localparam int OFF_W  = $clog2(BITS_PER_BLOCK);
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int WPB_W  = OFF_W - BIT_W;
  localparam int WORDS  = (NUM_BLOCKS * BITS_PER_BLOCK) / WORD_BITS;
  localparam int ADDR_W = $clog2(WORDS);

  localparam int HASH_W = 64;
  localparam int STEP_LSB = 32;
  localparam int HC_W   = 6;
  localparam logic [HC_W-1:0] HC_RESET = HC_W'(4);
  localparam int CNT_W  = 32;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_TEST  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_READ,
    BK_CHECK,
    BK_CLEAR
  } bk_state_e;

  typedef struct packed {
    op_e              op;
    logic [BLK_W-1:0] blk;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] step;
    logic [HC_W-1:0]  probes;
  } item_t;

  typedef struct packed {
    logic init_busy;
  } bk_status_t;

endpackage

### hw/rtl/bbf_front.sv
// Command front end: accepts commands, holds the probe count, prepares queue entries.
module bbf_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                op_i,
  input  logic [bbf_pkg::HASH_W-1:0] hash_a_i,
  input  logic [bbf_pkg::HASH_W-1:0] hash_b_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bbf_pkg::HC_W-1:0]  cfg_data_i,
  input  logic                      q_full_i,
  input  bbf_pkg::bk_status_t       bk_status_i,
  output logic                      push_o,
  output bbf_pkg::item_t            item_o
);

  logic [bbf_pkg::HC_W-1:0] hash_count_q;
  logic [bbf_pkg::HC_W-1:0] hash_count_d;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_full_i | bk_status_i.init_busy;
  assign push_o      = start & ~busy;

  always_comb begin
    hash_count_d = hash_count_q;
    if (cfg_valid_i && cfg_ready_o) begin
      hash_count_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_count_q <= bbf_pkg::HC_RESET;
    end else begin
      hash_count_q <= hash_count_d;
    end
  end

  always_comb begin
    item_o.op     = bbf_pkg::op_e'(op_i);
    item_o.blk    = hash_a_i[bbf_pkg::BLK_W-1:0];
    item_o.off    = hash_b_i[bbf_pkg::OFF_W-1:0];
    item_o.step   = (hash_a_i[bbf_pkg::STEP_LSB +: bbf_pkg::OFF_W]
                     ^ hash_b_i[bbf_pkg::OFF_W-1:0])
                    | bbf_pkg::OFF_W'(1);
    item_o.probes = hash_count_q;
  end

endmodule

### hw/rtl/bbf_queue.sv
// Short command queue between the front end and the probe engine.
module bbf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bbf_pkg::item_t item_i,
  input  logic           pop_i,
  output bbf_pkg::item_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  bbf_pkg::item_t                 entry_q [bbf_pkg::QDEPTH];
  logic [bbf_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [bbf_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [bbf_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                           do_push;
  logic                           do_pop;

  assign full_o  = (cnt_q == bbf_pkg::QCNT_W'(bbf_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == bbf_pkg::QPTR_W'(bbf_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_q + bbf_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == bbf_pkg::QPTR_W'(bbf_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_q + bbf_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + bbf_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - bbf_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### hw/rtl/bbf_back.sv
// Probe engine: bit store, clearing sweep, probe loop, insertion count and results.
module bbf_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bbf_pkg::item_t           head_i,
  input  logic                     empty_i,
  output logic                     pop_o,
  output bbf_pkg::bk_status_t      status_o,
  output logic                     done_o,
  output logic                     maybe_present_o,
  output logic [bbf_pkg::CNT_W-1:0] items_added_o
);

  bbf_pkg::bk_state_e state_q, state_d;

  logic [bbf_pkg::WORD_BITS-1:0] mem_q [bbf_pkg::WORDS];
  logic [bbf_pkg::WORD_BITS-1:0] rdata_q;
  logic                          mem_we;
  logic                          mem_re;
  logic [bbf_pkg::ADDR_W-1:0]    mem_addr;
  logic [bbf_pkg::WORD_BITS-1:0] mem_wdata;

  bbf_pkg::item_t                item_q;
  logic                          load;
  logic [bbf_pkg::HC_W-1:0]      k_q, k_d;
  logic [bbf_pkg::OFF_W-1:0]     off_q, off_d;
  logic [bbf_pkg::ADDR_W-1:0]    sweep_q, sweep_d;
  logic [bbf_pkg::CNT_W-1:0]     count_q, count_d;
  logic                          done_q, done_d;
  logic                          present_q, present_d;

  logic [bbf_pkg::ADDR_W-1:0]    word_addr;
  logic [bbf_pkg::WORD_BITS-1:0] bit_mask;
  logic                          probe_bit;
  logic                          sweep_last;
  logic                          probes_done;

  assign word_addr   = {item_q.blk, off_q[bbf_pkg::OFF_W-1 -: bbf_pkg::WPB_W]};
  assign bit_mask    = bbf_pkg::WORD_BITS'(1) << off_q[bbf_pkg::BIT_W-1:0];
  assign probe_bit   = rdata_q[off_q[bbf_pkg::BIT_W-1:0]];
  assign sweep_last  = (sweep_q == bbf_pkg::ADDR_W'(bbf_pkg::WORDS - 1));
  assign probes_done = (k_q == item_q.probes);

  assign status_o.init_busy = (state_q == bbf_pkg::BK_INIT);
  assign done_o             = done_q;
  assign maybe_present_o    = present_q;
  assign items_added_o      = count_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbf_pkg::BK_INIT: begin
        if (sweep_last) begin
          state_d = bbf_pkg::BK_IDLE;
        end
      end
      bbf_pkg::BK_IDLE: begin
        if (!empty_i) begin
          unique case (head_i.op)
            bbf_pkg::OP_ADD,
            bbf_pkg::OP_TEST:  state_d = bbf_pkg::BK_READ;
            bbf_pkg::OP_CLEAR: state_d = bbf_pkg::BK_CLEAR;
            bbf_pkg::OP_NOP:   state_d = bbf_pkg::BK_IDLE;
          endcase
        end
      end
      bbf_pkg::BK_READ: begin
        state_d = probes_done ? bbf_pkg::BK_IDLE : bbf_pkg::BK_CHECK;
      end
      bbf_pkg::BK_CHECK: begin
        if (item_q.op == bbf_pkg::OP_TEST && !probe_bit) begin
          state_d = bbf_pkg::BK_IDLE;
        end else begin
          state_d = bbf_pkg::BK_READ;
        end
      end
      bbf_pkg::BK_CLEAR: begin
        if (sweep_last) begin
          state_d = bbf_pkg::BK_IDLE;
        end
      end
      default: state_d = bbf_pkg::BK_INIT;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    load      = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = word_addr;
    mem_wdata = rdata_q | bit_mask;
    k_d       = k_q;
    off_d     = off_q;
    sweep_d   = sweep_q;
    count_d   = count_q;
    done_d    = 1'b0;
    present_d = present_q;
    unique case (state_q)
      bbf_pkg::BK_INIT: begin
        mem_we    = 1'b1;
        mem_addr  = sweep_q;
        mem_wdata = '0;
        sweep_d   = sweep_q + bbf_pkg::ADDR_W'(1);
      end
      bbf_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          load    = 1'b1;
          k_d     = '0;
          off_d   = head_i.off;
          sweep_d = '0;
          if (head_i.op == bbf_pkg::OP_NOP) begin
            done_d    = 1'b1;
            present_d = 1'b0;
          end
        end
      end
      bbf_pkg::BK_READ: begin
        if (probes_done) begin
          done_d    = 1'b1;
          present_d = (item_q.op == bbf_pkg::OP_TEST);
          if (item_q.op == bbf_pkg::OP_ADD && count_q != '1) begin
            count_d = count_q + bbf_pkg::CNT_W'(1);
          end
        end else begin
          mem_re = 1'b1;
        end
      end
      bbf_pkg::BK_CHECK: begin
        mem_we = (item_q.op == bbf_pkg::OP_ADD);
        if (item_q.op == bbf_pkg::OP_TEST && !probe_bit) begin
          done_d    = 1'b1;
          present_d = 1'b0;
        end else begin
          k_d   = k_q + bbf_pkg::HC_W'(1);
          off_d = off_q + item_q.step;
        end
      end
      bbf_pkg::BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = sweep_q;
        mem_wdata = '0;
        sweep_d   = sweep_q + bbf_pkg::ADDR_W'(1);
        if (sweep_last) begin
          done_d    = 1'b1;
          present_d = 1'b0;
          count_d   = '0;
        end
      end
      default: begin
        sweep_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbf_pkg::BK_INIT;
      sweep_q <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= head_i;
    end
    k_q       <= k_d;
    off_q     <= off_d;
    present_q <= present_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

endmodule

### hw/rtl/blocked_bloom_filter.sv
// Blocked Bloom filter top level: front end, command queue and probe engine.
//
// A command is taken when start is high and busy is low; every command gives exactly one
// result, shown for one cycle with done_o, in command order, and the receiver cannot stall
// it. The filter is 64 blocks of 512 bits kept in a 512 x 64-bit single-port memory. Add
// and test run each probe as a read, then a check or write back, on that memory port; a
// test ends at the first clear bit. Clear sweeps the memory one word a cycle. After reset
// the same sweep runs with busy high. A two-entry queue lets up to two commands wait while
// the engine works; once that first sweep is over, busy is high only when the queue is
// full.
module blocked_bloom_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 op_i,
  input  logic [bbf_pkg::HASH_W-1:0] hash_a_i,
  input  logic [bbf_pkg::HASH_W-1:0] hash_b_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bbf_pkg::HC_W-1:0]   cfg_data_i,
  output logic                       done_o,
  output logic                       maybe_present_o,
  output logic [bbf_pkg::CNT_W-1:0]  items_added_o
);

  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;
  bbf_pkg::item_t      push_item;
  bbf_pkg::item_t      head_item;
  bbf_pkg::bk_status_t bk_status;

  bbf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .hash_a_i    (hash_a_i),
    .hash_b_i    (hash_b_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .bk_status_i (bk_status),
    .push_o      (push),
    .item_o      (push_item)
  );

  bbf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  bbf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_item),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .status_o        (bk_status),
    .done_o          (done_o),
    .maybe_present_o (maybe_present_o),
    .items_added_o   (items_added_o)
  );

endmodule

### hw/rtl/bbf_checker.sv
// Port-level checks for the blocked Bloom filter, bound to the top level.
module bbf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       busy,
  input logic                       done_o,
  input logic                       maybe_present_o,
  input logic [bbf_pkg::CNT_W-1:0]  items_added_o
);

  a_busy_in_reset: assert property (@(posedge clk_i) !rst_ni |=> busy)
    else $error("busy low during reset");

  a_count_moves_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(items_added_o) |-> done_o)
    else $error("insertion count changed without a result");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(items_added_o) |->
      (items_added_o == '0) ||
      (items_added_o == bbf_pkg::CNT_W'($past(items_added_o) + bbf_pkg::CNT_W'(1))))
    else $error("insertion count jumped");

  a_hit_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && maybe_present_o |-> $stable(items_added_o))
    else $error("positive test changed the insertion count");

endmodule

bind blocked_bloom_filter bbf_checker u_bbf_checker (.*);
